@@ rtl/kwm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package kwm_pkg;

  localparam int NUM_STREAMS_DEF = 8;
  localparam int ID_BITS_DEF     = 32;

  localparam int IDX_W   = 3;
  localparam int HEAD_W  = 32;
  localparam int MASK_W  = 8;
  localparam int CNT_W   = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MERGE_MODE     = 1'b0,
    REG_ACTIVE_STREAMS = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    MODE_OR  = 1'b0,
    MODE_AND = 1'b1
  } merge_mode_t;

  localparam logic [CNT_W-1:0] ACTIVE_RST = CNT_W'(8);

endpackage

`default_nettype wire

@@ rtl/kway_sorted_merge_and_or_top.sv @@
// A result passes through the s1 input register and then the output register to out_valid.
// Throughput: one input item per cycle while in_stall is low; the pairwise head compare
// matrix over the stored and incoming stream heads settles within that cycle.
// Reset (rst_n low, synchronous): run state, handshake and config registers
// return to defaults; the per-stream head store is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module kway_sorted_merge_and_or_top #(
  parameter int NUM_STREAMS = kwm_pkg::NUM_STREAMS_DEF,
  parameter int ID_BITS     = kwm_pkg::ID_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [kwm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [kwm_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [kwm_pkg::IDX_W-1:0]       in_stream_index,
  input  wire logic [kwm_pkg::HEAD_W-1:0]      in_head_id,
  input  wire logic                            in_stream_ended,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic                                 out_id_valid,
  output logic [kwm_pkg::HEAD_W-1:0]           out_id,
  output logic [kwm_pkg::MASK_W-1:0]           out_refill_mask,
  output logic                                 out_run_done
);

  localparam int NCNT_W = $clog2(NUM_STREAMS + 1);

  kwm_pkg::merge_mode_t            mode_r;
  logic [kwm_pkg::CNT_W-1:0]       active_r;

  logic                            s1_v_r;
  logic [kwm_pkg::IDX_W-1:0]       s1_idx_r;
  logic [ID_BITS-1:0]              s1_head_r;
  logic                            s1_end_r;

  logic [ID_BITS-1:0]              head_r [NUM_STREAMS];
  logic [NUM_STREAMS-1:0]          pend_r, pend_nxt;
  logic [NUM_STREAMS-1:0]          dead_r, dead_nxt;
  logic [ID_BITS-1:0]              last_r, last_nxt;
  logic                            last_v_r, last_v_nxt;

  logic                            out_valid_r;
  logic                            out_id_valid_r;
  logic [kwm_pkg::HEAD_W-1:0]      out_id_r;
  logic [kwm_pkg::MASK_W-1:0]      out_mask_r;
  logic                            out_done_r;

  logic                            go, fire;
  logic [NCNT_W-1:0]               n_eff;
  logic [NUM_STREAMS-1:0]          all_mask, hit, pend1, dead1, pv, at_min;
  logic [ID_BITS-1:0]              cur [NUM_STREAMS];
  logic [ID_BITS-1:0]              min_val;
  logic                            take, wr_head, ready_all, found, every, emit, res_v;

  assign go       = !out_valid_r || !out_stall;
  assign fire     = s1_v_r && go;
  assign in_stall = s1_v_r && !go;

  always_comb begin
    if (active_r == '0) begin
      n_eff = NCNT_W'(1);
    end else if (int'(active_r) > NUM_STREAMS) begin
      n_eff = NCNT_W'(NUM_STREAMS);
    end else begin
      n_eff = NCNT_W'(active_r);
    end
    for (int i = 0; i < NUM_STREAMS; i++) begin
      all_mask[i] = int'(n_eff) > i;
      hit[i]      = int'(s1_idx_r) == i;
    end
    take    = fire && (int'(s1_idx_r) < int'(n_eff)) && ((hit & (pend_r | dead_r)) == '0);
    wr_head = take && !s1_end_r;
    pend1   = pend_r | (wr_head ? hit : '0);
    dead1   = dead_r | ((take && s1_end_r) ? hit : '0);
    for (int i = 0; i < NUM_STREAMS; i++) begin
      cur[i] = (wr_head && hit[i]) ? s1_head_r : head_r[i];
    end
    pv = pend1 & all_mask;
    for (int i = 0; i < NUM_STREAMS; i++) begin
      at_min[i] = pv[i];
      for (int j = 0; j < NUM_STREAMS; j++) begin
        if (pv[j] && (cur[j] < cur[i])) begin
          at_min[i] = 1'b0;
        end
      end
    end
    min_val = '0;
    for (int i = 0; i < NUM_STREAMS; i++) begin
      min_val = min_val | (at_min[i] ? cur[i] : '0);
    end
    ready_all = ((pend1 | dead1) & all_mask) == all_mask;
    found     = pv != '0;
    every     = at_min == all_mask;
    emit      = !(last_v_r && (min_val == last_r)) && !((mode_r == kwm_pkg::MODE_AND) && !every);
    res_v     = take && ready_all;

    pend_nxt   = pend1;
    dead_nxt   = dead1;
    last_nxt   = last_r;
    last_v_nxt = last_v_r;
    if (res_v) begin
      if (!found) begin
        pend_nxt   = '0;
        dead_nxt   = '0;
        last_nxt   = '0;
        last_v_nxt = 1'b0;
      end else begin
        pend_nxt = pend1 & ~at_min;
        if (emit) begin
          last_nxt   = min_val;
          last_v_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= kwm_pkg::MODE_OR;
      active_r <= kwm_pkg::ACTIVE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        kwm_pkg::REG_MERGE_MODE:     mode_r   <= kwm_pkg::merge_mode_t'(cfg_data[0]);
        kwm_pkg::REG_ACTIVE_STREAMS: active_r <= cfg_data[kwm_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (!in_stall) begin
      s1_v_r <= in_valid;
    end
    if (in_valid && !in_stall) begin
      s1_idx_r  <= in_stream_index;
      s1_head_r <= ID_BITS'(in_head_id);
      s1_end_r  <= in_stream_ended;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_STREAMS; i++) begin
      if (wr_head && hit[i]) begin
        head_r[i] <= s1_head_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r   <= '0;
      dead_r   <= '0;
      last_r   <= '0;
      last_v_r <= 1'b0;
    end else begin
      pend_r   <= pend_nxt;
      dead_r   <= dead_nxt;
      last_r   <= last_nxt;
      last_v_r <= last_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= res_v;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (res_v) begin
      out_id_valid_r <= found && emit;
      out_id_r       <= (found && emit) ? kwm_pkg::HEAD_W'(min_val) : '0;
      out_mask_r     <= found ? kwm_pkg::MASK_W'(at_min) : '0;
      out_done_r     <= !found;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_id_valid    = out_id_valid_r;
  assign out_id          = out_id_r;
  assign out_refill_mask = out_mask_r;
  assign out_run_done    = out_done_r;

endmodule

`default_nettype wire

@@ rtl/kwm_chk.sv @@
`timescale 1ns / 1ps
`default_nettype none

module kwm_chk (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_valid,
  input wire logic                            in_stall,
  input wire logic                            out_valid,
  input wire logic                            out_stall,
  input wire logic                            out_id_valid,
  input wire logic [kwm_pkg::HEAD_W-1:0]      out_id,
  input wire logic [kwm_pkg::MASK_W-1:0]      out_refill_mask,
  input wire logic                            out_run_done
);

  a_done_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_run_done |-> !out_id_valid && out_id == '0 && out_refill_mask == '0)
    else $error("done transfer carries id or refill bits");

  a_no_id_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_id_valid |-> out_id == '0)
    else $error("suppressed id is nonzero");

  a_refill_any: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_run_done |-> out_refill_mask != '0)
    else $error("merge transfer releases no stream");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_id) && $stable(out_refill_mask))
    else $error("stalled result changed");

  a_in_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |-> out_valid && out_stall)
    else $error("input stalled while result side is free");

endmodule

bind kway_sorted_merge_and_or_top kwm_chk u_kwm_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_id_valid    (out_id_valid),
  .out_id          (out_id),
  .out_refill_mask (out_refill_mask),
  .out_run_done    (out_run_done)
);

`default_nettype wire

@@ tb/kway_sorted_merge_and_or_top_tb.sv @@
`timescale 1ns / 1ps

module kway_sorted_merge_and_or_top_tb;

  localparam int NSTR = kwm_pkg::NUM_STREAMS_DEF;

  typedef struct packed {
    logic                       id_valid;
    logic [kwm_pkg::HEAD_W-1:0] id;
    logic [kwm_pkg::MASK_W-1:0] refill;
    logic                       done;
  } merge_result_t;

  class merge_scoreboard;
    kwm_pkg::merge_mode_t       mode;
    logic [kwm_pkg::CNT_W-1:0]  active_cfg;
    logic [kwm_pkg::HEAD_W-1:0] heads [NSTR];
    logic [kwm_pkg::MASK_W-1:0] pending;
    logic [kwm_pkg::MASK_W-1:0] dead;
    logic [kwm_pkg::HEAD_W-1:0] last_id;
    logic                       last_ok;
    merge_result_t              due_results [$];
    int                         errors;
    int                         done_count;

    function new();
      mode = kwm_pkg::MODE_OR;
      active_cfg = kwm_pkg::ACTIVE_RST;
      pending = '0;
      dead = '0;
      last_id = '0;
      last_ok = 1'b0;
      errors = 0;
      done_count = 0;
    endfunction

    function void set_reg(kwm_pkg::cfg_reg_t r, logic [kwm_pkg::CFG_DATA_W-1:0] d);
      if (r == kwm_pkg::REG_MERGE_MODE) mode = kwm_pkg::merge_mode_t'(d[0]);
      else active_cfg = d;
    endfunction

    function int unsigned stream_count();
      if (active_cfg == 0) return 1;
      if (active_cfg > NSTR) return NSTR;
      return active_cfg;
    endfunction

    // Returns 1 when the head is taken, 0 when the block ignores it.
    function bit take_head(logic [kwm_pkg::IDX_W-1:0] idx, logic [kwm_pkg::HEAD_W-1:0] head,
                           logic ended);
      int unsigned                n;
      logic [kwm_pkg::MASK_W-1:0] b;
      logic [kwm_pkg::MASK_W-1:0] live;
      logic [kwm_pkg::MASK_W-1:0] at_min;
      logic [kwm_pkg::HEAD_W-1:0] min_id;
      logic                       found;
      logic                       all_hit;
      logic                       emit;
      merge_result_t              r;
      n = stream_count();
      if (idx >= n) return 0;
      b = kwm_pkg::MASK_W'(1) << idx;
      if (((pending | dead) & b) != 0) return 0;
      if (ended) dead |= b;
      else begin
        heads[idx] = head;
        pending |= b;
      end
      live = '0;
      for (int i = 0; i < n; i++) live[i] = 1'b1;
      if (((pending | dead) & live) != live) return 1;
      found = 1'b0;
      min_id = '0;
      for (int i = 0; i < n; i++) begin
        if (pending[i] && (!found || heads[i] < min_id)) begin
          min_id = heads[i];
          found = 1'b1;
        end
      end
      r = '0;
      if (!found) begin
        pending = '0;
        dead = '0;
        last_id = '0;
        last_ok = 1'b0;
        r.done = 1'b1;
        due_results.push_back(r);
        done_count++;
        return 1;
      end
      at_min = '0;
      all_hit = 1'b1;
      for (int i = 0; i < n; i++) begin
        if (pending[i] && heads[i] == min_id) at_min[i] = 1'b1;
        else all_hit = 1'b0;
      end
      emit = !(last_ok && min_id == last_id);
      if (mode == kwm_pkg::MODE_AND && !all_hit) emit = 1'b0;
      if (emit) begin
        last_id = min_id;
        last_ok = 1'b1;
      end
      pending &= ~at_min;
      r.id_valid = emit;
      r.id = emit ? min_id : '0;
      r.refill = at_min;
      due_results.push_back(r);
      return 1;
    endfunction

    function void check_result(logic id_valid, logic [kwm_pkg::HEAD_W-1:0] id,
                               logic [kwm_pkg::MASK_W-1:0] refill, logic done);
      merge_result_t e;
      if (due_results.size() == 0) begin
        $display("%0t: result: expected none, actual id_valid=%0b id=%h refill=%h done=%0b",
                 $time, id_valid, id, refill, done);
        errors++;
        return;
      end
      e = due_results.pop_front();
      if (e.id_valid !== id_valid) begin
        $display("%0t: id_valid: expected %0b, actual %0b", $time, e.id_valid, id_valid);
        errors++;
      end
      if (e.id !== id) begin
        $display("%0t: out_id: expected %h, actual %h", $time, e.id, id);
        errors++;
      end
      if (e.refill !== refill) begin
        $display("%0t: refill_mask: expected %h, actual %h", $time, e.refill, refill);
        errors++;
      end
      if (e.done !== done) begin
        $display("%0t: run_done: expected %0b, actual %0b", $time, e.done, done);
        errors++;
      end
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           cfg_we = 1'b0;
  logic [kwm_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [kwm_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic [kwm_pkg::IDX_W-1:0]      in_stream_index = '0;
  logic [kwm_pkg::HEAD_W-1:0]     in_head_id = '0;
  logic                           in_stream_ended = 1'b0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic                           out_id_valid;
  logic [kwm_pkg::HEAD_W-1:0]     out_id;
  logic [kwm_pkg::MASK_W-1:0]     out_refill_mask;
  logic                           out_run_done;

  merge_scoreboard sb;
  int  in_pct = 0;
  int  out_pct = 0;
  int  stall_left = 0;
  int  items_done = 0;
  bit  calm = 1'b0;
  int  pcts [4] = '{0, 10, 30, 60};

  kway_sorted_merge_and_or_top dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_stream_index(in_stream_index),
    .in_head_id(in_head_id),
    .in_stream_ended(in_stream_ended),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_id_valid(out_id_valid),
    .out_id(out_id),
    .out_refill_mask(out_refill_mask),
    .out_run_done(out_run_done)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (!calm && stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 99) < out_pct) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 4);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && sb != null && out_valid && !out_stall)
      sb.check_result(out_id_valid, out_id, out_refill_mask, out_run_done);
  end

  task automatic send_item(logic [kwm_pkg::IDX_W-1:0] idx, logic [kwm_pkg::HEAD_W-1:0] head,
                           logic ended);
    if (!calm && $urandom_range(0, 99) < in_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_stream_index <= idx;
    in_head_id <= head;
    in_stream_ended <= ended;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (sb.take_head(idx, head, ended)) begin
      items_done++;
      calm = items_done >= 900;
    end
  endtask

  task automatic write_reg(kwm_pkg::cfg_reg_t r, logic [kwm_pkg::CFG_DATA_W-1:0] d);
    in_valid <= 1'b0;
    while (sb.due_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= r;
    cfg_data <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(r, d);
  endtask

  function automatic bit pending_or_dead(int unsigned i);
    return sb.pending[i] | sb.dead[i];
  endfunction

  // Feed one complete merge: refill whichever streams are waiting until done.
  task automatic feed_merge();
    int unsigned                n;
    int unsigned                s;
    int unsigned                shape;
    int unsigned                avg_len;
    int                         seen;
    logic [kwm_pkg::HEAD_W:0]   nxt;
    logic [kwm_pkg::HEAD_W-1:0] step;
    logic [kwm_pkg::HEAD_W-1:0] prev [NSTR];
    int unsigned                cand [$];
    seen = sb.done_count;
    shape = $urandom_range(0, 3);
    avg_len = $urandom_range(0, 10);
    for (int i = 0; i < NSTR; i++) begin
      case (shape)
        0: prev[i] = $urandom_range(0, 4);
        1: prev[i] = $urandom >> $urandom_range(0, 31);
        2: prev[i] = 32'hFFFF_FFF0 + $urandom_range(0, 15);
        default: prev[i] = $urandom_range(0, 64);
      endcase
    end
    while (sb.done_count == seen) begin
      if ($urandom_range(0, 99) < 8) begin
        send_item(kwm_pkg::IDX_W'($urandom_range(0, NSTR - 1)), $urandom,
                  1'($urandom_range(0, 1)));
        continue;
      end
      n = sb.stream_count();
      cand.delete();
      for (int i = 0; i < n; i++)
        if (!pending_or_dead(i)) cand.push_back(i);
      if (cand.size() == 0) break;
      s = cand[$urandom_range(0, cand.size() - 1)];
      if ($urandom_range(0, avg_len) == 0) begin
        send_item(kwm_pkg::IDX_W'(s), $urandom, 1'b1);
      end else begin
        case (shape)
          0: step = $urandom_range(0, 2);
          1: step = $urandom >> $urandom_range(0, 31);
          2: step = $urandom_range(0, 3);
          default: step = $urandom_range(0, 20);
        endcase
        nxt = {1'b0, prev[s]} + step;
        if (nxt[kwm_pkg::HEAD_W]) nxt = {1'b0, {kwm_pkg::HEAD_W{1'b1}}};
        if ($urandom_range(0, 99) < 3) nxt = {1'b0, $urandom};
        prev[s] = nxt[kwm_pkg::HEAD_W-1:0];
        send_item(kwm_pkg::IDX_W'(s), prev[s], 1'b0);
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    in_pct = 20;
    out_pct = 20;

    write_reg(kwm_pkg::REG_MERGE_MODE, 4'(kwm_pkg::MODE_OR));
    write_reg(kwm_pkg::REG_ACTIVE_STREAMS, 4'd2);
    send_item(3'd0, 32'h0000_0000, 1'b0);
    send_item(3'd0, 32'h0000_0005, 1'b0);
    send_item(3'd5, 32'h0000_0001, 1'b0);
    send_item(3'd1, 32'hFFFF_FFFF, 1'b0);
    send_item(3'd0, 32'h0000_0000, 1'b0);
    send_item(3'd0, 32'h0000_0000, 1'b1);
    send_item(3'd0, 32'h0000_0003, 1'b0);
    send_item(3'd1, 32'hA5A5_5A5A, 1'b1);

    write_reg(kwm_pkg::REG_MERGE_MODE, 4'(kwm_pkg::MODE_AND));
    write_reg(kwm_pkg::REG_ACTIVE_STREAMS, 4'd3);
    send_item(3'd0, 32'd7, 1'b0);
    send_item(3'd1, 32'd7, 1'b0);
    send_item(3'd2, 32'd7, 1'b0);
    send_item(3'd0, 32'd9, 1'b0);
    send_item(3'd1, 32'd8, 1'b0);
    send_item(3'd2, 32'd9, 1'b0);
    send_item(3'd1, 32'd9, 1'b0);
    send_item(3'd0, 32'd0, 1'b1);
    send_item(3'd1, 32'd10, 1'b0);
    send_item(3'd2, 32'd10, 1'b0);
    send_item(3'd1, 32'd0, 1'b1);
    send_item(3'd2, 32'd0, 1'b1);

    write_reg(kwm_pkg::REG_MERGE_MODE, 4'b1110);
    write_reg(kwm_pkg::REG_ACTIVE_STREAMS, 4'd0);
    send_item(3'd0, 32'h8000_0000, 1'b0);
    send_item(3'd1, 32'd5, 1'b0);
    send_item(3'd0, 32'd0, 1'b1);

    write_reg(kwm_pkg::REG_ACTIVE_STREAMS, 4'd15);
    send_item(3'd7, 32'hFFFF_FFFF, 1'b0);

    while (items_done < 1000) begin
      in_pct = pcts[$urandom_range(0, 3)];
      out_pct = pcts[$urandom_range(0, 3)];
      feed_merge();
      if ($urandom_range(0, 1) == 1)
        write_reg(kwm_pkg::REG_MERGE_MODE, kwm_pkg::CFG_DATA_W'($urandom_range(0, 15)));
      if ($urandom_range(0, 9) < 6) begin
        case ($urandom_range(0, 6))
          0: write_reg(kwm_pkg::REG_ACTIVE_STREAMS, 4'd0);
          1: write_reg(kwm_pkg::REG_ACTIVE_STREAMS, 4'd1);
          2: write_reg(kwm_pkg::REG_ACTIVE_STREAMS, 4'd2);
          3: write_reg(kwm_pkg::REG_ACTIVE_STREAMS, 4'd8);
          4: write_reg(kwm_pkg::REG_ACTIVE_STREAMS, 4'd15);
          5: write_reg(kwm_pkg::REG_ACTIVE_STREAMS,
                       kwm_pkg::CFG_DATA_W'($urandom_range(1, 8)));
          default: write_reg(kwm_pkg::REG_ACTIVE_STREAMS,
                             kwm_pkg::CFG_DATA_W'($urandom_range(0, 15)));
        endcase
      end
    end

    in_valid <= 1'b0;
    while (sb.due_results.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (sb.errors == 0)
      $display("PASS kway_sorted_merge_and_or_top");
    else
      $display("FAIL kway_sorted_merge_and_or_top");
    $finish;
  end

  initial begin
    #10000000;
    $display("FAIL kway_sorted_merge_and_or_top");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/kwm_pkg.sv
rtl/kway_sorted_merge_and_or_top.sv
rtl/kwm_chk.sv
tb/kway_sorted_merge_and_or_top_tb.sv
